@@ src/mac_control_element_encoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// mac control element encoder assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef MAC_CONTROL_ELEMENT_ENCODER_CORE_ASSERT_SVH
`define MAC_CONTROL_ELEMENT_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define MCEE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCEE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mcee_pkg.sv @@
// ----------------------------------------------------------------------------
// mcee_pkg
// shared constants, codes and types of the mac control element encoder
// ----------------------------------------------------------------------------
`default_nettype none

package mcee_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W     = 17;

	// action codes
	localparam logic [3:0] ACT_SHORT_BSR = 4'd0;
	localparam logic [3:0] ACT_PHR       = 4'd1;
	localparam logic [3:0] ACT_CRNTI     = 4'd2;
	localparam logic [3:0] ACT_BIT_RATE  = 4'd3;
	localparam logic [3:0] ACT_SL_LBT    = 4'd4;
	localparam logic [3:0] ACT_EXT_BSR   = 4'd5;
	localparam logic [3:0] ACT_DSR_ENTRY = 4'd6;
	localparam logic [3:0] ACT_EPHR_ENTRY = 4'd7;
	localparam logic [3:0] ACT_BFR_HEAD  = 4'd8;
	localparam logic [3:0] ACT_BFR_ENTRY = 4'd9;

	// header octets
	localparam logic [7:0] EXT_LCID     = 8'h3F;
	localparam logic [7:0] ELCID_DSR    = 8'd228;
	localparam logic [7:0] ELCID_EPHR   = 8'd221;
	localparam logic [7:0] ELCID_SLLBT  = 8'd222;
	localparam logic [7:0] ELCID_BFR    = 8'd235;
	localparam logic [7:0] ELCID_EXTBSR = 8'd245;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;
	localparam logic [1:0] ERR_SEQ   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SHORT_BSR_LCID = 3'd0;
	localparam logic [2:0] REG_PHR_LCID       = 3'd1;
	localparam logic [2:0] REG_CRNTI_LCID     = 3'd2;
	localparam logic [2:0] REG_BIT_RATE_LCID  = 3'd3;
	localparam logic [2:0] REG_PHR_P_FLAG     = 3'd4;
	localparam logic [2:0] REG_PHR_MPE_FLAG   = 3'd5;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_DSR  = 2'd1,
		KIND_EPHR = 2'd2,
		KIND_BFR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_HDR  = 2'd1,
		BK_ENT  = 2'd2
	} bk_state_t;

	typedef struct packed {
		logic [5:0] short_bsr_lcid;
		logic [5:0] phr_lcid;
		logic [5:0] crnti_lcid;
		logic [5:0] bit_rate_lcid;
		logic       phr_p_flag;
		logic       phr_mpe_flag;
	} cfg_t;

	// one job for the back end: header octets, then count stored entries
	typedef struct packed {
		logic             err;
		logic [1:0]       err_code;
		logic [3:0][7:0]  hdr;
		logic [2:0]       n_hdr;
		kind_t            kind;
		logic [CNT_W-1:0] count;
	} job_t;

endpackage

`default_nettype wire

@@ src/mcee_front.sv @@
// ----------------------------------------------------------------------------
// mcee_front
// checks each request, keeps the open list and hands jobs to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mcee_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mcee_pkg::cfg_t                cfg,
	input  wire logic                          accept,
	input  wire logic [3:0]                    action,
	input  wire logic [15:0]                   first_value,
	input  wire logic [7:0]                    second_value,
	input  wire logic [7:0]                    third_value,
	input  wire logic                          last_entry,
	output mcee_pkg::job_t                     job,
	output logic                               job_push,
	output logic                               busy,
	input  wire logic                          list_done,
	input  wire logic [mcee_pkg::IDX_W-1:0]    rd_idx,
	output logic [mcee_pkg::ENTRY_W-1:0]       rd_word
);

	logic [mcee_pkg::ENTRY_W-1:0] store_q [mcee_pkg::MAX_ENTRIES];
	logic [mcee_pkg::CNT_W-1:0]   count_q;
	mcee_pkg::kind_t              kind_q;
	logic [7:0]                   bitmap_q;
	logic [7:0]                   cell_q;
	logic [7:0]                   sp_q;
	logic                         busy_q;

	logic                         c_err;
	logic [1:0]                   c_code;
	logic                         c_fixed;
	logic [3:0][7:0]              c_hdr;
	logic [2:0]                   c_n;
	logic                         c_add;
	logic                         c_head;
	mcee_pkg::kind_t              c_kind;
	logic [mcee_pkg::ENTRY_W-1:0] c_word;
	logic [7:0]                   bitmap_nxt;
	logic                         list_open;
	logic                         drop;

	assign list_open = (kind_q != mcee_pkg::KIND_NONE);
	assign rd_word   = store_q[rd_idx];
	assign busy      = busy_q;

	// classify the request
	always_comb begin
		c_err  = 1'b0;
		c_code = mcee_pkg::ERR_NONE;
		c_fixed = 1'b0;
		c_hdr  = '0;
		c_n    = 3'd1;
		c_add  = 1'b0;
		c_head = 1'b0;
		c_kind = mcee_pkg::KIND_NONE;
		c_word = '0;
		if (action > mcee_pkg::ACT_BFR_ENTRY) begin
			c_err  = 1'b1;
			c_code = mcee_pkg::ERR_RANGE;
		end else if (action <= mcee_pkg::ACT_EXT_BSR && list_open) begin
			c_err  = 1'b1;
			c_code = mcee_pkg::ERR_SEQ;
		end else begin
			case (action)
				mcee_pkg::ACT_SHORT_BSR: begin
					c_err   = (|first_value[15:3]) | (|second_value[7:5]);
					c_fixed = 1'b1;
					c_n     = 3'd2;
					c_hdr[0] = {2'b00, cfg.short_bsr_lcid};
					c_hdr[1] = {first_value[2:0], second_value[4:0]};
				end
				mcee_pkg::ACT_PHR: begin
					c_err   = (|first_value[15:6]) | (|second_value[7:6]);
					c_fixed = 1'b1;
					c_n     = 3'd3;
					c_hdr[0] = {2'b00, cfg.phr_lcid};
					c_hdr[1] = {cfg.phr_p_flag, 1'b0, first_value[5:0]};
					c_hdr[2] = {cfg.phr_mpe_flag, 1'b0, second_value[5:0]};
				end
				mcee_pkg::ACT_CRNTI: begin
					c_fixed = 1'b1;
					c_n     = 3'd3;
					c_hdr[0] = {2'b00, cfg.crnti_lcid};
					c_hdr[1] = first_value[15:8];
					c_hdr[2] = first_value[7:0];
				end
				mcee_pkg::ACT_BIT_RATE: begin
					c_err   = (|first_value[15:6]) | (|second_value[7:6])
						| (|third_value[7:1]);
					c_fixed = 1'b1;
					c_n     = 3'd3;
					c_hdr[0] = {2'b00, cfg.bit_rate_lcid};
					c_hdr[1] = {first_value[5:0], third_value[0], second_value[5]};
					c_hdr[2] = {second_value[4:0], 3'b000};
				end
				mcee_pkg::ACT_SL_LBT: begin
					c_err   = |first_value[15:5];
					c_fixed = 1'b1;
					c_n     = 3'd3;
					c_hdr[0] = mcee_pkg::EXT_LCID;
					c_hdr[1] = mcee_pkg::ELCID_SLLBT;
					c_hdr[2] = first_value[7:0];
				end
				mcee_pkg::ACT_EXT_BSR: begin
					c_err   = |first_value[15:3];
					c_fixed = 1'b1;
					c_n     = 3'd4;
					c_hdr[0] = mcee_pkg::EXT_LCID;
					c_hdr[1] = mcee_pkg::ELCID_EXTBSR;
					c_hdr[2] = first_value[7:0];
					c_hdr[3] = second_value;
				end
				mcee_pkg::ACT_DSR_ENTRY: begin
					if (list_open && kind_q != mcee_pkg::KIND_DSR) begin
						c_err  = 1'b1;
						c_code = mcee_pkg::ERR_SEQ;
					end else begin
						c_err  = (|first_value[15:3]) | (|second_value[7:6]);
						c_add  = 1'b1;
						c_kind = mcee_pkg::KIND_DSR;
						c_word = {first_value[2:0], second_value[5:0], third_value};
					end
				end
				mcee_pkg::ACT_EPHR_ENTRY: begin
					if (list_open && kind_q != mcee_pkg::KIND_EPHR) begin
						c_err  = 1'b1;
						c_code = mcee_pkg::ERR_SEQ;
					end else begin
						c_err  = (|first_value[15:6]) | (|second_value[7:6]);
						c_add  = 1'b1;
						c_kind = mcee_pkg::KIND_EPHR;
						c_word = {5'd0, first_value[5:0], second_value[5:0]};
					end
				end
				mcee_pkg::ACT_BFR_HEAD: begin
					if (list_open) begin
						c_err  = 1'b1;
						c_code = mcee_pkg::ERR_SEQ;
					end else begin
						c_err  = |first_value[15:8];
						c_head = 1'b1;
					end
				end
				default: begin
					if (kind_q != mcee_pkg::KIND_BFR) begin
						c_err  = 1'b1;
						c_code = mcee_pkg::ERR_SEQ;
					end else begin
						c_err  = (|first_value[15:1]) | (|second_value[7:1])
							| (|third_value[7:6]);
						c_add  = 1'b1;
						c_kind = mcee_pkg::KIND_BFR;
						c_word = {9'd0, first_value[0], second_value[0], third_value[5:0]};
					end
				end
			endcase
			// range failures that did not already carry a sequence code
			if (c_err && c_code == mcee_pkg::ERR_NONE) begin
				c_code = mcee_pkg::ERR_RANGE;
			end
			if (!c_err && c_add
				&& count_q >= mcee_pkg::CNT_W'(mcee_pkg::MAX_ENTRIES)) begin
				c_err  = 1'b1;
				c_code = mcee_pkg::ERR_LONG;
			end
		end
	end

	assign bitmap_nxt = (c_kind == mcee_pkg::KIND_DSR)
		? (bitmap_q | (8'd1 << c_word[16:14])) : bitmap_q;

	// job handed to the back end
	always_comb begin
		job          = '0;
		job.err      = c_err;
		job.err_code = c_code;
		job.n_hdr    = 3'd1;
		job.kind     = mcee_pkg::KIND_NONE;
		if (c_err) begin
			job.n_hdr = 3'd1;
		end else if (c_fixed) begin
			job.hdr   = c_hdr;
			job.n_hdr = c_n;
		end else begin
			job.kind   = c_kind;
			job.count  = count_q + mcee_pkg::CNT_W'(1);
			job.hdr[0] = mcee_pkg::EXT_LCID;
			case (c_kind)
				mcee_pkg::KIND_DSR: begin
					job.hdr[1] = mcee_pkg::ELCID_DSR;
					job.hdr[2] = bitmap_nxt;
					job.n_hdr  = 3'd3;
				end
				mcee_pkg::KIND_EPHR: begin
					job.hdr[1] = mcee_pkg::ELCID_EPHR;
					job.n_hdr  = 3'd2;
				end
				default: begin
					job.hdr[1] = mcee_pkg::ELCID_BFR;
					job.hdr[2] = cell_q;
					job.hdr[3] = sp_q;
					job.n_hdr  = 3'd4;
				end
			endcase
		end
	end

	assign job_push = accept && (c_err || c_fixed || (c_add && last_entry));
	assign drop     = c_err || (c_add && last_entry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			kind_q   <= mcee_pkg::KIND_NONE;
			bitmap_q <= '0;
			cell_q   <= '0;
			sp_q     <= '0;
			busy_q   <= 1'b0;
		end else begin
			if (list_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				if (drop) begin
					count_q  <= '0;
					kind_q   <= mcee_pkg::KIND_NONE;
					bitmap_q <= '0;
					cell_q   <= '0;
					sp_q     <= '0;
					// the store stays with the back end until the list is out
					if (!c_err) begin
						busy_q <= 1'b1;
					end
				end else if (c_add) begin
					count_q  <= count_q + mcee_pkg::CNT_W'(1);
					kind_q   <= c_kind;
					bitmap_q <= bitmap_nxt;
				end else if (c_head) begin
					count_q <= '0;
					kind_q  <= mcee_pkg::KIND_BFR;
					cell_q  <= first_value[7:0];
					sp_q    <= second_value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && c_add && !c_err) begin
			store_q[count_q[mcee_pkg::IDX_W-1:0]] <= c_word;
		end
	end

endmodule

`default_nettype wire

@@ src/mcee_queue.sv @@
// ----------------------------------------------------------------------------
// mcee_queue
// two-entry job queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module mcee_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mcee_pkg::job_t wr_job,
	input  wire logic           pop,
	output mcee_pkg::job_t      rd_job,
	output logic                full,
	output logic                empty
);

	mcee_pkg::job_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign full   = (fill_q == 2'd2);
	assign empty  = (fill_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

@@ src/mcee_back.sv @@
// ----------------------------------------------------------------------------
// mcee_back
// octet sequencer: walks header octets and stored entries into the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "mac_control_element_encoder_core_assert.svh"

module mcee_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire mcee_pkg::job_t                q_job,
	output logic                               q_pop,
	output logic [mcee_pkg::IDX_W-1:0]         rd_idx,
	input  wire logic [mcee_pkg::ENTRY_W-1:0]  rd_word,
	output logic                               list_done,
	output logic [7:0]                         out_byte,
	output logic                               last_byte,
	output logic                               error_flag,
	output logic [1:0]                         error_code,
	output logic                               empty,
	input  wire logic                          pop
);

	mcee_pkg::bk_state_t        state_q;
	mcee_pkg::bk_state_t        state_d;
	mcee_pkg::job_t             job_q;
	logic [1:0]                 hdr_idx_q;
	logic [mcee_pkg::IDX_W-1:0] ent_idx_q;
	logic                       half_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_byte_q;
	logic                       error_flag_q;
	logic [1:0]                 error_code_q;

	logic                       slot_free;
	logic                       hdr_end;
	logic                       ent_end;
	logic                       emit;
	logic [7:0]                 em_byte;
	logic                       em_last;

	assign slot_free = !out_valid_q || pop;
	assign hdr_end   = ({1'b0, hdr_idx_q} == job_q.n_hdr - 3'd1);
	assign ent_end   = (mcee_pkg::CNT_W'(ent_idx_q) == job_q.count - mcee_pkg::CNT_W'(1))
		&& (job_q.kind == mcee_pkg::KIND_BFR || half_q);
	assign rd_idx    = ent_idx_q;

	// outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		em_byte   = '0;
		em_last   = 1'b0;
		list_done = 1'b0;
		case (state_q)
			mcee_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			mcee_pkg::BK_HDR: begin
				emit    = slot_free;
				em_byte = job_q.err ? 8'd0 : job_q.hdr[hdr_idx_q];
				em_last = job_q.err || (hdr_end && job_q.count == '0);
			end
			mcee_pkg::BK_ENT: begin
				emit    = slot_free;
				em_last = ent_end;
				list_done = slot_free && ent_end;
				case (job_q.kind)
					mcee_pkg::KIND_DSR:
						em_byte = half_q ? rd_word[7:0] : {2'b00, rd_word[13:8]};
					mcee_pkg::KIND_EPHR:
						em_byte = half_q ? {2'b10, rd_word[5:0]} : {2'b10, rd_word[11:6]};
					default:
						em_byte = rd_word[7:0];
				endcase
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcee_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = mcee_pkg::BK_HDR;
				end
			end
			mcee_pkg::BK_HDR: begin
				if (slot_free) begin
					if (em_last) begin
						state_d = mcee_pkg::BK_IDLE;
					end else if (hdr_end) begin
						state_d = mcee_pkg::BK_ENT;
					end
				end
			end
			mcee_pkg::BK_ENT: begin
				if (slot_free && ent_end) begin
					state_d = mcee_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mcee_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcee_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			hdr_idx_q   <= '0;
			ent_idx_q   <= '0;
			half_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				hdr_idx_q <= '0;
				ent_idx_q <= '0;
				half_q    <= 1'b0;
			end else if (emit && state_q == mcee_pkg::BK_HDR) begin
				hdr_idx_q <= hdr_idx_q + 2'd1;
			end else if (emit && state_q == mcee_pkg::BK_ENT) begin
				if (job_q.kind == mcee_pkg::KIND_BFR || half_q) begin
					ent_idx_q <= ent_idx_q + mcee_pkg::IDX_W'(1);
					half_q    <= 1'b0;
				end else begin
					half_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			out_byte_q   <= em_byte;
			last_byte_q  <= em_last;
			error_flag_q <= job_q.err && state_q == mcee_pkg::BK_HDR;
			error_code_q <= (state_q == mcee_pkg::BK_HDR) ? job_q.err_code
				: mcee_pkg::ERR_NONE;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;
	assign error_flag = error_flag_q;
	assign error_code = error_code_q;

	`MCEE_ASSERT_IMP(a_done_in_ent, list_done, state_q == mcee_pkg::BK_ENT, "list end outside entry phase")
	`MCEE_ASSERT_NXT(a_pop_starts, q_pop, state_q == mcee_pkg::BK_HDR, "job taken but header not started")
	`MCEE_ASSERT_IMP(a_ent_has_count, state_q == mcee_pkg::BK_ENT, job_q.count != '0, "entry phase with empty list")
	`MCEE_ASSERT_IMP(a_err_single, out_valid_q && error_flag_q, last_byte_q && out_byte_q == 8'd0, "error result not a lone closing result")

endmodule

`default_nettype wire

@@ src/mac_control_element_encoder_core.sv @@
// ----------------------------------------------------------------------------
// mac control element encoder core
// turns requests into mac control element octets, one octet per result
// ----------------------------------------------------------------------------
// usage
//  - requests enter through push/full; results leave through empty/pop, one
//    octet per transaction, the last octet of an element (or a lone error
//    result) carrying last_byte
//  - the front end checks each request at once and records list entries; a
//    fixed element, an error or the closing entry of a list becomes a job in
//    a two-entry queue, so the front can take requests while octets drain
//  - the back end pops a job, then writes one octet per cycle into the result
//    register while the receiver keeps popping
//  - a closing list entry holds full high until the last stored entry has
//    been read out, since the entries stay in the front end's store: up to
//    3 + 2 * 8 octets for a full list
//  - if the receiver stops popping, the result register holds its octet, the
//    sequencer waits, the queue fills and full rises; nothing is dropped
//  - reset: registers take their default lcids and flags, no list is open,
//    queue and result register are empty
//  - registers sit on the apb port at byte address 4 * index; pready is tied
//    high; the user, unchecked by the block, writes only while it is idle
// ----------------------------------------------------------------------------
`default_nettype none

module mac_control_element_encoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        push,
	output logic             full,
	input  wire logic [3:0]  action,
	input  wire logic [15:0] first_value,
	input  wire logic [7:0]  second_value,
	input  wire logic [7:0]  third_value,
	input  wire logic        last_entry,
	// result channel
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_byte,
	output logic             error_flag,
	output logic [1:0]       error_code,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	mcee_pkg::cfg_t               cfg_q;
	mcee_pkg::job_t               fr_job;
	mcee_pkg::job_t               q_job;
	logic                         fr_push;
	logic                         fr_busy;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_pop;
	logic                         list_done;
	logic                         accept;
	logic                         cfg_wr;
	logic [2:0]                   reg_idx;
	logic [mcee_pkg::IDX_W-1:0]   rd_idx;
	logic [mcee_pkg::ENTRY_W-1:0] rd_word;

	// request taken when the queue has room and no list is draining
	assign full   = q_full || fr_busy;
	assign accept = push && !full;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_bsr_lcid <= 6'd61;
			cfg_q.phr_lcid       <= 6'd57;
			cfg_q.crnti_lcid     <= 6'd58;
			cfg_q.bit_rate_lcid  <= 6'd47;
			cfg_q.phr_p_flag     <= 1'b1;
			cfg_q.phr_mpe_flag   <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				mcee_pkg::REG_SHORT_BSR_LCID: cfg_q.short_bsr_lcid <= pwdata[5:0];
				mcee_pkg::REG_PHR_LCID:       cfg_q.phr_lcid       <= pwdata[5:0];
				mcee_pkg::REG_CRNTI_LCID:     cfg_q.crnti_lcid     <= pwdata[5:0];
				mcee_pkg::REG_BIT_RATE_LCID:  cfg_q.bit_rate_lcid  <= pwdata[5:0];
				mcee_pkg::REG_PHR_P_FLAG:     cfg_q.phr_p_flag     <= pwdata[0];
				mcee_pkg::REG_PHR_MPE_FLAG:   cfg_q.phr_mpe_flag   <= pwdata[0];
				default:                      cfg_q <= cfg_q;
			endcase
		end
	end

	// read back, zero beyond the register list
	always_comb begin
		case (reg_idx)
			mcee_pkg::REG_SHORT_BSR_LCID: prdata = {26'd0, cfg_q.short_bsr_lcid};
			mcee_pkg::REG_PHR_LCID:       prdata = {26'd0, cfg_q.phr_lcid};
			mcee_pkg::REG_CRNTI_LCID:     prdata = {26'd0, cfg_q.crnti_lcid};
			mcee_pkg::REG_BIT_RATE_LCID:  prdata = {26'd0, cfg_q.bit_rate_lcid};
			mcee_pkg::REG_PHR_P_FLAG:     prdata = {31'd0, cfg_q.phr_p_flag};
			mcee_pkg::REG_PHR_MPE_FLAG:   prdata = {31'd0, cfg_q.phr_mpe_flag};
			default:                      prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// front end: checks, list bookkeeping, entry store
	// ------------------------------------------------------------------
	mcee_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.action       (action),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.last_entry   (last_entry),
		.job          (fr_job),
		.job_push     (fr_push),
		.busy         (fr_busy),
		.list_done    (list_done),
		.rd_idx       (rd_idx),
		.rd_word      (rd_word)
	);

	// ------------------------------------------------------------------
	// job queue decoupling the two halves
	// ------------------------------------------------------------------
	mcee_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wr_job (fr_job),
		.pop    (q_pop),
		.rd_job (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// ------------------------------------------------------------------
	// back end: octet sequencer and result register
	// ------------------------------------------------------------------
	mcee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (q_job),
		.q_pop      (q_pop),
		.rd_idx     (rd_idx),
		.rd_word    (rd_word),
		.list_done  (list_done),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.error_flag (error_flag),
		.error_code (error_code),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

`default_nettype wire

@@ sim/mac_control_element_encoder_core_test.sv @@
// ----------------------------------------------------------------------------
// mac control element encoder core testbench
// drives encode requests through the push/full side and checks every octet
// popped from the empty/pop side against an in-bench prediction of the
// encoder; register settings change between phases while the block is idle
// ----------------------------------------------------------------------------

module mac_control_element_encoder_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import mcee_pkg::*;

	// cycles with no transaction on any port before the run is abandoned
	localparam int STALL_LIMIT   = 2000;
	// quiet cycles after the last expected octet, longer than one full list
	localparam int SETTLE_CYCLES = 32;
	// long receiver hold-off, enough to fill the job queue and raise full
	localparam int HOLD_OFF      = 150;

	// one request as presented on the input side
	typedef struct {
		logic [3:0]  act;
		logic [15:0] a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic        last;
	} ce_request_t;

	// one octet transaction as seen on the result side
	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       err;
		logic [1:0] code;
	} ce_octet_t;

	// ------------------------------------------------------------------------
	// scoreboard: own copy of the encoder state, expected octet store, checks
	// ------------------------------------------------------------------------
	class ce_scoreboard;
		cfg_t               regs;
		logic [ENTRY_W-1:0] entry_words [MAX_ENTRIES];
		int unsigned        stored;
		kind_t              open_kind;
		logic [7:0]         group_mask;
		logic [7:0]         beam_cell;
		logic [7:0]         beam_sp;
		ce_octet_t          expected_octets [$];
		int unsigned        mismatches;
		int unsigned        octets_checked;
		int unsigned        errors_predicted;

		function new();
			regs.short_bsr_lcid = 6'd61;
			regs.phr_lcid       = 6'd57;
			regs.crnti_lcid     = 6'd58;
			regs.bit_rate_lcid  = 6'd47;
			regs.phr_p_flag     = 1'b1;
			regs.phr_mpe_flag   = 1'b1;
			mismatches       = 0;
			octets_checked   = 0;
			errors_predicted = 0;
			clear_list();
		endfunction

		function void clear_list();
			open_kind  = KIND_NONE;
			stored     = 0;
			group_mask = '0;
			beam_cell  = '0;
			beam_sp    = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_SHORT_BSR_LCID: regs.short_bsr_lcid = value[5:0];
				REG_PHR_LCID:       regs.phr_lcid       = value[5:0];
				REG_CRNTI_LCID:     regs.crnti_lcid     = value[5:0];
				REG_BIT_RATE_LCID:  regs.bit_rate_lcid  = value[5:0];
				REG_PHR_P_FLAG:     regs.phr_p_flag     = value[0];
				REG_PHR_MPE_FLAG:   regs.phr_mpe_flag   = value[0];
				default: ;
			endcase
		endfunction

		function void add_octet(logic [7:0] value);
			ce_octet_t o;
			o.value = value;
			o.last  = 1'b0;
			o.err   = 1'b0;
			o.code  = ERR_NONE;
			expected_octets.push_back(o);
		endfunction

		function void mark_last();
			ce_octet_t o;
			o = expected_octets.pop_back();
			o.last = 1'b1;
			expected_octets.push_back(o);
		endfunction

		// a rejection throws away any open list and gives one lone error octet
		function void reject(logic [1:0] code);
			ce_octet_t o;
			clear_list();
			o.value = '0;
			o.last  = 1'b1;
			o.err   = 1'b1;
			o.code  = code;
			expected_octets.push_back(o);
			errors_predicted++;
		endfunction

		function void emit_list();
			int i;
			add_octet(EXT_LCID);
			case (open_kind)
				KIND_DSR: begin
					add_octet(ELCID_DSR);
					add_octet(group_mask);
					for (i = 0; i < stored; i++) begin
						add_octet({2'b00, entry_words[i][13:8]});
						add_octet(entry_words[i][7:0]);
					end
				end
				KIND_EPHR: begin
					add_octet(ELCID_EPHR);
					for (i = 0; i < stored; i++) begin
						add_octet({2'b10, entry_words[i][11:6]});
						add_octet({2'b10, entry_words[i][5:0]});
					end
				end
				default: begin
					add_octet(ELCID_BFR);
					add_octet(beam_cell);
					add_octet(beam_sp);
					for (i = 0; i < stored; i++)
						add_octet(entry_words[i][7:0]);
				end
			endcase
			clear_list();
			mark_last();
		endfunction

		function void store_entry(kind_t kind, logic [ENTRY_W-1:0] word, logic last);
			if (stored >= MAX_ENTRIES) begin
				reject(ERR_LONG);
				return;
			end
			entry_words[stored] = word;
			stored++;
			open_kind = kind;
			if (kind == KIND_DSR)
				group_mask[word[16:14]] = 1'b1;
			if (last)
				emit_list();
		endfunction

		// order of checks: unknown action, then sequence, then range, then list length
		function void note_request(ce_request_t req);
			if (req.act > ACT_BFR_ENTRY) begin
				reject(ERR_RANGE);
				return;
			end
			if (req.act <= ACT_EXT_BSR && open_kind != KIND_NONE) begin
				reject(ERR_SEQ);
				return;
			end
			case (req.act)
				ACT_SHORT_BSR: begin
					if (req.a > 7 || req.b > 31) begin
						reject(ERR_RANGE);
					end else begin
						add_octet({2'b00, regs.short_bsr_lcid});
						add_octet({req.a[2:0], req.b[4:0]});
						mark_last();
					end
				end
				ACT_PHR: begin
					if (req.a > 63 || req.b > 63) begin
						reject(ERR_RANGE);
					end else begin
						add_octet({2'b00, regs.phr_lcid});
						add_octet({regs.phr_p_flag, 1'b0, req.a[5:0]});
						add_octet({regs.phr_mpe_flag, 1'b0, req.b[5:0]});
						mark_last();
					end
				end
				ACT_CRNTI: begin
					add_octet({2'b00, regs.crnti_lcid});
					add_octet(req.a[15:8]);
					add_octet(req.a[7:0]);
					mark_last();
				end
				ACT_BIT_RATE: begin
					if (req.a > 63 || req.b > 63 || req.c > 1) begin
						reject(ERR_RANGE);
					end else begin
						add_octet({2'b00, regs.bit_rate_lcid});
						add_octet({req.a[5:0], req.c[0], req.b[5]});
						add_octet({req.b[4:0], 3'b000});
						mark_last();
					end
				end
				ACT_SL_LBT: begin
					if (req.a > 31) begin
						reject(ERR_RANGE);
					end else begin
						add_octet(EXT_LCID);
						add_octet(ELCID_SLLBT);
						add_octet(req.a[7:0]);
						mark_last();
					end
				end
				ACT_EXT_BSR: begin
					if (req.a > 7) begin
						reject(ERR_RANGE);
					end else begin
						add_octet(EXT_LCID);
						add_octet(ELCID_EXTBSR);
						add_octet(req.a[7:0]);
						add_octet(req.b);
						mark_last();
					end
				end
				ACT_DSR_ENTRY: begin
					if (open_kind != KIND_NONE && open_kind != KIND_DSR)
						reject(ERR_SEQ);
					else if (req.a > 7 || req.b > 63)
						reject(ERR_RANGE);
					else
						store_entry(KIND_DSR, {req.a[2:0], req.b[5:0], req.c}, req.last);
				end
				ACT_EPHR_ENTRY: begin
					if (open_kind != KIND_NONE && open_kind != KIND_EPHR)
						reject(ERR_SEQ);
					else if (req.a > 63 || req.b > 63)
						reject(ERR_RANGE);
					else
						store_entry(KIND_EPHR, {5'b0, req.a[5:0], req.b[5:0]}, req.last);
				end
				ACT_BFR_HEAD: begin
					// last_entry plays no part on a head
					if (open_kind != KIND_NONE) begin
						reject(ERR_SEQ);
					end else if (req.a > 255) begin
						reject(ERR_RANGE);
					end else begin
						open_kind = KIND_BFR;
						stored    = 0;
						beam_cell = req.a[7:0];
						beam_sp   = req.b;
					end
				end
				default: begin
					if (open_kind != KIND_BFR)
						reject(ERR_SEQ);
					else if (req.a > 1 || req.b > 1 || req.c > 63)
						reject(ERR_RANGE);
					else
						store_entry(KIND_BFR, {9'b0, req.a[0], req.b[0], req.c[5:0]},
							req.last);
				end
			endcase
		endfunction

		function void check_octet(ce_octet_t got);
			ce_octet_t want;
			octets_checked++;
			if (expected_octets.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected octet %02h last %0b err %0b code %0d",
						got.value, got.last, got.err, got.code);
				return;
			end
			want = expected_octets.pop_front();
			if (got.value !== want.value || got.last !== want.last ||
				got.err !== want.err || got.code !== want.code) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"octet mismatch: expected %02h last %0b err %0b code %0d,",
						" got %02h last %0b err %0b code %0d"},
						want.value, want.last, want.err, want.code,
						got.value, got.last, got.err, got.code);
			end
		endfunction

		function int pending();
			return expected_octets.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals and block under test
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [3:0]  action;
	logic [15:0] first_value;
	logic [7:0]  second_value;
	logic [7:0]  third_value;
	logic        last_entry;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        last_byte;
	logic        error_flag;
	logic [1:0]  error_code;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ce_scoreboard sb = new();

	int unsigned requests_sent;
	int unsigned settings_used;
	int unsigned idle_cycles;
	int          hold_cycles;   // set by the stimulus, consumed by the result sink
	bit          no_idle;       // both sides run back to back while set

	mac_control_element_encoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.last_entry   (last_entry),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.error_flag   (error_flag),
		.error_code   (error_code),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: any transaction on either side or the register port counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 3);
	endfunction

	// ------------------------------------------------------------------------
	// request side; every task is entered just after a rising edge
	// ------------------------------------------------------------------------
	task automatic send_request(input logic [3:0] act, input logic [15:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic last);
		int gap;
		ce_request_t req;
		gap = draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		action       <= act;
		first_value  <= a;
		second_value <= b;
		third_value  <= c;
		last_entry   <= last;
		// full is sampled before the edge updates land
		do @(posedge clk); while (full);
		req.act  = act;
		req.a    = a;
		req.b    = b;
		req.c    = c;
		req.last = last;
		sb.note_request(req);
		requests_sent++;
	endtask

	task automatic end_requests();
		push <= 1'b0;
	endtask

	// wait for every predicted octet, then a quiet spell for stragglers
	task automatic settle();
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup phase, access phase, then psel low again before returning
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper bits of each write carry noise, the register keeps only its width
	task automatic program_regs(input logic [5:0] bsr, input logic [5:0] phr,
		input logic [5:0] rnti, input logic [5:0] rate, input logic p, input logic mpe);
		write_reg(REG_SHORT_BSR_LCID, ($urandom() & ~32'h3F) | bsr);
		write_reg(REG_PHR_LCID,       ($urandom() & ~32'h3F) | phr);
		write_reg(REG_CRNTI_LCID,     ($urandom() & ~32'h3F) | rnti);
		write_reg(REG_BIT_RATE_LCID,  ($urandom() & ~32'h3F) | rate);
		write_reg(REG_PHR_P_FLAG,     ($urandom() & ~32'h1) | p);
		write_reg(REG_PHR_MPE_FLAG,   ($urandom() & ~32'h1) | mpe);
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// random request shapes
	// ------------------------------------------------------------------------
	function automatic kind_t pick_kind();
		return kind_t'($urandom_range(1, 3));
	endfunction

	// fixed-format element with in-range content, spare fields random
	task automatic rand_fixed();
		logic [3:0]  act;
		logic [15:0] a;
		logic [7:0]  b;
		logic [7:0]  c;
		act = 4'($urandom_range(0, 5));
		a   = 16'($urandom());
		b   = 8'($urandom());
		c   = 8'($urandom());
		case (act)
			ACT_SHORT_BSR: begin
				a = 16'($urandom_range(0, 7));
				b = 8'($urandom_range(0, 31));
			end
			ACT_PHR: begin
				a = 16'($urandom_range(0, 63));
				b = 8'($urandom_range(0, 63));
			end
			ACT_CRNTI: ;
			ACT_BIT_RATE: begin
				a = 16'($urandom_range(0, 63));
				b = 8'($urandom_range(0, 63));
				c = 8'($urandom_range(0, 1));
			end
			ACT_SL_LBT: a = 16'($urandom_range(0, 31));
			default:    a = 16'($urandom_range(0, 7));
		endcase
		send_request(act, a, b, c, 1'($urandom()));
	endtask

	task automatic rand_entry(input kind_t kind, input logic last);
		case (kind)
			KIND_DSR: send_request(ACT_DSR_ENTRY, 16'($urandom_range(0, 7)),
				8'($urandom_range(0, 63)), 8'($urandom()), last);
			KIND_EPHR: send_request(ACT_EPHR_ENTRY, 16'($urandom_range(0, 63)),
				8'($urandom_range(0, 63)), 8'($urandom()), last);
			default: send_request(ACT_BFR_ENTRY, 16'($urandom_range(0, 1)),
				8'($urandom_range(0, 1)), 8'($urandom_range(0, 63)), last);
		endcase
	endtask

	// n entries of one kind (after a head for bfr), closed by last_entry on the final one if asked
	task automatic rand_list(input kind_t kind, input int n, input bit close);
		int i;
		if (kind == KIND_BFR)
			send_request(ACT_BFR_HEAD, 16'($urandom_range(0, 255)), 8'($urandom()),
				8'($urandom()), 1'($urandom()));
		for (i = 0; i < n; i++)
			rand_entry(kind, close && (i == n - 1));
	endtask

	// noise and broken sequences
	task automatic rand_broken();
		kind_t kind;
		kind = pick_kind();
		case ($urandom_range(0, 3))
			0: send_request(4'($urandom()), 16'($urandom()), 8'($urandom()),
				8'($urandom()), 1'($urandom()));
			1: rand_list(kind, MAX_ENTRIES + 1, 1'b0);
			2: begin
				// open list followed by a fixed element or another entry
				rand_list(kind, $urandom_range(1, 3), 1'b0);
				if ($urandom_range(0, 1))
					rand_fixed();
				else
					rand_entry(pick_kind(), 1'($urandom()));
			end
			default: begin
				// entry with unrestricted content, mostly out of range
				case (kind)
					KIND_DSR:  send_request(ACT_DSR_ENTRY, 16'($urandom()), 8'($urandom()),
						8'($urandom()), 1'($urandom()));
					KIND_EPHR: send_request(ACT_EPHR_ENTRY, 16'($urandom()), 8'($urandom()),
						8'($urandom()), 1'($urandom()));
					default:   send_request(ACT_BFR_ENTRY, 16'($urandom()), 8'($urandom()),
						8'($urandom()), 1'($urandom()));
				endcase
			end
		endcase
	endtask

	task automatic run_random(input int count);
		int unsigned target;
		int pick;
		int n;
		target = requests_sent + count;
		while (requests_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				rand_fixed();
			end else if (pick < 85) begin
				// mostly short lists, now and then up to a full store
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, MAX_ENTRIES)
					: $urandom_range(1, 3);
				rand_list(pick_kind(), n, 1'b1);
			end else begin
				rand_broken();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// directed opening: field extremes, every action, each error path
	// ------------------------------------------------------------------------
	task automatic run_directed();
		int i;
		send_request(ACT_SHORT_BSR, 16'd7, 8'd31, 8'd0, 1'b0);
		send_request(ACT_SHORT_BSR, 16'd8, 8'd0, 8'd0, 1'b0);        // lcg too big
		send_request(ACT_PHR, 16'd63, 8'd63, 8'hFF, 1'b1);
		send_request(ACT_PHR, 16'd0, 8'd64, 8'd0, 1'b0);             // pcmax too big
		send_request(ACT_CRNTI, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_request(ACT_BIT_RATE, 16'd63, 8'd63, 8'd1, 1'b0);
		send_request(ACT_BIT_RATE, 16'd0, 8'd0, 8'd2, 1'b0);         // bad ul/dl
		send_request(ACT_SL_LBT, 16'd31, 8'd0, 8'd0, 1'b0);
		send_request(ACT_SL_LBT, 16'd32, 8'd0, 8'd0, 1'b0);          // lbt bits too wide
		send_request(ACT_EXT_BSR, 16'd7, 8'd255, 8'd0, 1'b0);
		send_request(ACT_DSR_ENTRY, 16'd7, 8'd63, 8'd255, 1'b0);
		send_request(ACT_DSR_ENTRY, 16'd0, 8'd0, 8'd0, 1'b1);
		send_request(ACT_EPHR_ENTRY, 16'd63, 8'd63, 8'd0, 1'b1);
		// last flag on a head is ignored, the list stays open
		send_request(ACT_BFR_HEAD, 16'd255, 8'd255, 8'd0, 1'b1);
		send_request(ACT_BFR_ENTRY, 16'd1, 8'd1, 8'd63, 1'b1);
		// head while a list is open: sequence wins over range
		send_request(ACT_DSR_ENTRY, 16'd1, 8'd2, 8'd3, 1'b0);
		send_request(ACT_BFR_HEAD, 16'd256, 8'd0, 8'd0, 1'b0);
		send_request(ACT_BFR_HEAD, 16'd256, 8'd0, 8'd0, 1'b0);       // cell id too big
		// entry for the wrong list kind
		send_request(ACT_BFR_HEAD, 16'd3, 8'd1, 8'd0, 1'b0);
		send_request(ACT_EPHR_ENTRY, 16'd1, 8'd1, 8'd0, 1'b1);
		// unknown action drops the open list, so the bfr entry is out of sequence
		send_request(ACT_BFR_HEAD, 16'd0, 8'd0, 8'd0, 1'b0);
		send_request(4'd15, 16'd0, 8'd0, 8'd0, 1'b0);
		send_request(ACT_BFR_ENTRY, 16'd0, 8'd0, 8'd0, 1'b1);
		// one entry more than the store holds
		for (i = 0; i <= MAX_ENTRIES; i++)
			send_request(ACT_EPHR_ENTRY, 16'(i), 8'(i), 8'd0, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// result side: pops with random hold-offs, checks every transaction
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int gap;
		ce_octet_t got;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (hold_cycles > 0 || gap > 0) begin
				pop <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.value = out_byte;
			got.last  = last_byte;
			got.err   = error_flag;
			got.code  = error_code;
			sb.check_octet(got);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		push          = 1'b0;
		action        = '0;
		first_value   = '0;
		second_value  = '0;
		third_value   = '0;
		last_entry    = 1'b0;
		pop           = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		requests_sent = 0;
		settings_used = 1;
		idle_cycles   = 0;
		hold_cycles   = 0;
		no_idle       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		run_directed();
		run_random(40);
		end_requests();
		settle();

		// top of every register; receiver stalls long enough to back up the input
		program_regs(6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1);
		hold_cycles = HOLD_OFF;
		run_random(90);
		end_requests();
		settle();

		// bottom of every register, both sides back to back
		program_regs(6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0);
		no_idle = 1'b1;
		run_random(90);
		no_idle = 1'b0;
		end_requests();
		settle();

		// mixed setting
		program_regs(6'($urandom()), 6'($urandom()), 6'($urandom()), 6'($urandom()),
			1'($urandom()), 1'($urandom()));
		run_random(90);
		end_requests();
		settle();

		$display("covered %0d requests under %0d register settings, one long receiver stall",
			requests_sent, settings_used);
		$display("checked %0d octets, %0d of the predictions were rejections, %0d mismatches",
			sb.octets_checked, sb.errors_predicted, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
